@@ rtl/core/mvp_pkg.sv @@
// Shared types, constants and helper functions for the mecanum velocity PID block.
package mvp_pkg;

    localparam int DATA_W     = 32;
    localparam int COEF_W     = 16;
    localparam int SCALE_W    = 16;
    localparam int GAIN_W     = 48;
    localparam int NUM_LANES  = 3;
    localparam int LANE_W     = 2;
    localparam int MUL_A_W    = 34;
    localparam int MUL_B_W    = 17;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int ACC_W      = PROD_W;
    localparam int DIFF_W     = DATA_W + 1;
    localparam int FRAC_SHIFT = 16;
    localparam int GAIN_SHIFT = 8;
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;
    localparam int ADDR_LSB   = 3;

    localparam logic [LANE_W-1:0] LANE_X   = 2'd0;
    localparam logic [LANE_W-1:0] LANE_Y   = 2'd1;
    localparam logic [LANE_W-1:0] LANE_YAW = 2'd2;

    localparam logic [SCALE_W-1:0] LINEAR_SCALE_RST   = 16'd1262;
    localparam logic [SCALE_W-1:0] ROTATION_SCALE_RST = 16'd3906;
    localparam logic [SCALE_W-1:0] SAMPLE_PERIOD_RST  = 16'd655;
    localparam logic [SCALE_W-1:0] SAMPLE_RATE_RST    = 16'd100;

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    typedef enum logic [2:0] {
        REG_GAINS_X,
        REG_GAINS_Y,
        REG_GAINS_YAW,
        REG_LINEAR_SCALE,
        REG_ROTATION_SCALE,
        REG_SAMPLE_PERIOD,
        REG_SAMPLE_RATE
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  gains_x;
        logic [GAIN_W-1:0]  gains_y;
        logic [GAIN_W-1:0]  gains_yaw;
        logic [SCALE_W-1:0] linear_scale;
        logic [SCALE_W-1:0] rotation_scale;
        logic [SCALE_W-1:0] sample_period;
        logic [SCALE_W-1:0] sample_rate;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_MEAS,
        OP_ERR,
        OP_PERIOD,
        OP_RATE,
        OP_KP,
        OP_KI,
        OP_KD,
        OP_DRIVE
    } op_t;

    typedef struct packed {
        logic              load_in;
        op_t               op;
        logic [LANE_W-1:0] lane;
        logic              load_out;
    } dp_cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MEAS,
        S_ERR,
        S_PERIOD,
        S_RATE,
        S_KP,
        S_KI,
        S_KD,
        S_DRIVE,
        S_LOAD
    } state_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > S32_MAX)
        begin
            r = S32_MAX[DATA_W-1:0];
        end
        else if (v < S32_MIN)
        begin
            r = S32_MIN[DATA_W-1:0];
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/mvp_if.sv @@
// Valid/ready channel interfaces for wheel samples in and PID results out.
interface mvp_in_if
    import mvp_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] wheel_front_right;
    logic signed [DATA_W-1:0] wheel_front_left;
    logic signed [DATA_W-1:0] wheel_rear_left;
    logic signed [DATA_W-1:0] wheel_rear_right;
    logic signed [DATA_W-1:0] goal_x;
    logic signed [DATA_W-1:0] goal_y;
    logic signed [DATA_W-1:0] goal_yaw;

    modport source (
        output valid, wheel_front_right, wheel_front_left, wheel_rear_left,
               wheel_rear_right, goal_x, goal_y, goal_yaw,
        input  ready
    );

    modport sink (
        input  valid, wheel_front_right, wheel_front_left, wheel_rear_left,
               wheel_rear_right, goal_x, goal_y, goal_yaw,
        output ready
    );
endinterface

interface mvp_out_if
    import mvp_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] drive_x;
    logic signed [DATA_W-1:0] drive_y;
    logic signed [DATA_W-1:0] drive_yaw;
    logic signed [DATA_W-1:0] measured_x;
    logic signed [DATA_W-1:0] measured_y;
    logic signed [DATA_W-1:0] measured_yaw;
    logic signed [DATA_W-1:0] error_x;
    logic signed [DATA_W-1:0] error_y;
    logic signed [DATA_W-1:0] error_yaw;

    modport source (
        output valid, drive_x, drive_y, drive_yaw, measured_x, measured_y,
               measured_yaw, error_x, error_y, error_yaw,
        input  ready
    );

    modport sink (
        input  valid, drive_x, drive_y, drive_yaw, measured_x, measured_y,
               measured_yaw, error_x, error_y, error_yaw,
        output ready
    );
endinterface

@@ rtl/core/mecanum_velocity_pid_top.sv @@
// Top level of the mecanum velocity PID block: register file, sequencer and datapath.
// Each accepted sample is worked on for x, y and yaw in turn, stepping each axis through
// measure, error, period, rate, kp, ki, kd and drive, all on one shared 34 by 17 bit
// multiplier whose product is registered; a load step then moves the results into the
// output register, after which a new sample can be taken while the last result still
// waits for its transfer; the next load step then waits until that result has been taken.
// Configuration registers are 64 bits wide at byte address 8 times their index and
// should be written only while the block is idle.
module mecanum_velocity_pid_top
    import mvp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    mvp_in_if.sink                sample_in,
    mvp_out_if.source             result_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t    cfg;
    dp_cmd_t cmd;

    mvp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mvp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_in.valid),
        .in_ready  (sample_in.ready),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .cmd       (cmd)
    );

    mvp_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg),
        .cmd               (cmd),
        .wheel_front_right (sample_in.wheel_front_right),
        .wheel_front_left  (sample_in.wheel_front_left),
        .wheel_rear_left   (sample_in.wheel_rear_left),
        .wheel_rear_right  (sample_in.wheel_rear_right),
        .goal_x            (sample_in.goal_x),
        .goal_y            (sample_in.goal_y),
        .goal_yaw          (sample_in.goal_yaw),
        .drive_x           (result_out.drive_x),
        .drive_y           (result_out.drive_y),
        .drive_yaw         (result_out.drive_yaw),
        .measured_x        (result_out.measured_x),
        .measured_y        (result_out.measured_y),
        .measured_yaw      (result_out.measured_yaw),
        .error_x           (result_out.error_x),
        .error_y           (result_out.error_y),
        .error_yaw         (result_out.error_yaw)
    );

endmodule

@@ rtl/core/mvp_regs.sv @@
// APB configuration register file holding gains, kinematic scales and timing.
module mvp_regs
    import mvp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [GAIN_W-1:0]  gains_x_reg;
    logic [GAIN_W-1:0]  gains_y_reg;
    logic [GAIN_W-1:0]  gains_yaw_reg;
    logic [SCALE_W-1:0] linear_scale_reg;
    logic [SCALE_W-1:0] rotation_scale_reg;
    logic [SCALE_W-1:0] sample_period_reg;
    logic [SCALE_W-1:0] sample_rate_reg;
    logic               wr_en;
    reg_idx_t           idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:ADDR_LSB]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_x_reg        <= '0;
            gains_y_reg        <= '0;
            gains_yaw_reg      <= '0;
            linear_scale_reg   <= LINEAR_SCALE_RST;
            rotation_scale_reg <= ROTATION_SCALE_RST;
            sample_period_reg  <= SAMPLE_PERIOD_RST;
            sample_rate_reg    <= SAMPLE_RATE_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_GAINS_X:        gains_x_reg        <= pwdata[GAIN_W-1:0];
                REG_GAINS_Y:        gains_y_reg        <= pwdata[GAIN_W-1:0];
                REG_GAINS_YAW:      gains_yaw_reg      <= pwdata[GAIN_W-1:0];
                REG_LINEAR_SCALE:   linear_scale_reg   <= pwdata[SCALE_W-1:0];
                REG_ROTATION_SCALE: rotation_scale_reg <= pwdata[SCALE_W-1:0];
                REG_SAMPLE_PERIOD:  sample_period_reg  <= pwdata[SCALE_W-1:0];
                REG_SAMPLE_RATE:    sample_rate_reg    <= pwdata[SCALE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_GAINS_X:        prdata = APB_DATA_W'(gains_x_reg);
            REG_GAINS_Y:        prdata = APB_DATA_W'(gains_y_reg);
            REG_GAINS_YAW:      prdata = APB_DATA_W'(gains_yaw_reg);
            REG_LINEAR_SCALE:   prdata = APB_DATA_W'(linear_scale_reg);
            REG_ROTATION_SCALE: prdata = APB_DATA_W'(rotation_scale_reg);
            REG_SAMPLE_PERIOD:  prdata = APB_DATA_W'(sample_period_reg);
            REG_SAMPLE_RATE:    prdata = APB_DATA_W'(sample_rate_reg);
            default:            prdata = '0;
        endcase
    end

    assign cfg.gains_x        = gains_x_reg;
    assign cfg.gains_y        = gains_y_reg;
    assign cfg.gains_yaw      = gains_yaw_reg;
    assign cfg.linear_scale   = linear_scale_reg;
    assign cfg.rotation_scale = rotation_scale_reg;
    assign cfg.sample_period  = sample_period_reg;
    assign cfg.sample_rate    = sample_rate_reg;

endmodule

@@ rtl/core/mvp_ctrl.sv @@
// Sequencing state machine that steps the datapath through each axis in turn.
module mvp_ctrl
    import mvp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    state_t            state_reg;
    state_t            state_next;
    logic [LANE_W-1:0] lane_reg;
    logic [LANE_W-1:0] lane_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lane_reg      <= LANE_X;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lane_reg      <= lane_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        lane_next    = lane_reg;
        in_ready     = 1'b0;
        cmd.load_in  = 1'b0;
        cmd.op       = OP_NONE;
        cmd.lane     = lane_reg;
        cmd.load_out = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    lane_next   = LANE_X;
                    state_next  = S_MEAS;
                end
            end
            S_MEAS:
            begin
                cmd.op     = OP_MEAS;
                state_next = S_ERR;
            end
            S_ERR:
            begin
                cmd.op     = OP_ERR;
                state_next = S_PERIOD;
            end
            S_PERIOD:
            begin
                cmd.op     = OP_PERIOD;
                state_next = S_RATE;
            end
            S_RATE:
            begin
                cmd.op     = OP_RATE;
                state_next = S_KP;
            end
            S_KP:
            begin
                cmd.op     = OP_KP;
                state_next = S_KI;
            end
            S_KI:
            begin
                cmd.op     = OP_KI;
                state_next = S_KD;
            end
            S_KD:
            begin
                cmd.op     = OP_KD;
                state_next = S_DRIVE;
            end
            S_DRIVE:
            begin
                cmd.op = OP_DRIVE;
                if (lane_reg == LANE_YAW)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    lane_next  = lane_reg + 1'b1;
                    state_next = S_MEAS;
                end
            end
            S_LOAD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ rtl/core/mvp_dp.sv @@
// Datapath with the shared multiplier, PID state per axis and the result registers.
module mvp_dp
    import mvp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  dp_cmd_t                  cmd,
    input  logic signed [DATA_W-1:0] wheel_front_right,
    input  logic signed [DATA_W-1:0] wheel_front_left,
    input  logic signed [DATA_W-1:0] wheel_rear_left,
    input  logic signed [DATA_W-1:0] wheel_rear_right,
    input  logic signed [DATA_W-1:0] goal_x,
    input  logic signed [DATA_W-1:0] goal_y,
    input  logic signed [DATA_W-1:0] goal_yaw,
    output logic signed [DATA_W-1:0] drive_x,
    output logic signed [DATA_W-1:0] drive_y,
    output logic signed [DATA_W-1:0] drive_yaw,
    output logic signed [DATA_W-1:0] measured_x,
    output logic signed [DATA_W-1:0] measured_y,
    output logic signed [DATA_W-1:0] measured_yaw,
    output logic signed [DATA_W-1:0] error_x,
    output logic signed [DATA_W-1:0] error_y,
    output logic signed [DATA_W-1:0] error_yaw
);

    logic signed [MUL_A_W-1:0] sum_reg [NUM_LANES];
    logic signed [DATA_W-1:0]  goal_reg [NUM_LANES];
    logic signed [DATA_W-1:0]  integ_reg [NUM_LANES];
    logic signed [DATA_W-1:0]  prior_reg [NUM_LANES];
    logic signed [DATA_W-1:0]  meas_res_reg [NUM_LANES];
    logic signed [DATA_W-1:0]  err_res_reg [NUM_LANES];
    logic signed [DATA_W-1:0]  drive_res_reg [NUM_LANES];
    logic signed [DATA_W-1:0]  meas_out_reg [NUM_LANES];
    logic signed [DATA_W-1:0]  err_out_reg [NUM_LANES];
    logic signed [DATA_W-1:0]  drive_out_reg [NUM_LANES];
    logic signed [DATA_W-1:0]  err_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [DATA_W-1:0]  deriv_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_sum;

    logic signed [MUL_A_W-1:0] w1, w2, w3, w4;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic [GAIN_W-1:0]         gains;
    logic [SCALE_W-1:0]        scale;
    logic signed [COEF_W-1:0]  kp, ki, kd;
    logic signed [DATA_W-1:0]  goal_cur;
    logic signed [DATA_W-1:0]  integ_cur;
    logic signed [DATA_W-1:0]  prior_cur;
    logic                      goal_zero;
    logic signed [DATA_W-1:0]  meas_val;
    logic signed [DATA_W-1:0]  err_val;
    logic signed [DATA_W-1:0]  integ_val;
    logic signed [DATA_W-1:0]  drive_val;

    assign w1 = MUL_A_W'(wheel_front_right);
    assign w2 = MUL_A_W'(wheel_front_left);
    assign w3 = MUL_A_W'(wheel_rear_left);
    assign w4 = MUL_A_W'(wheel_rear_right);

    always_comb
    begin
        case (cmd.lane)
            LANE_X:  gains = cfg.gains_x;
            LANE_Y:  gains = cfg.gains_y;
            default: gains = cfg.gains_yaw;
        endcase
    end

    assign scale     = (cmd.lane == LANE_YAW) ? cfg.rotation_scale : cfg.linear_scale;
    assign kp        = gains[COEF_W-1:0];
    assign ki        = gains[2*COEF_W-1:COEF_W];
    assign kd        = gains[3*COEF_W-1:2*COEF_W];
    assign goal_cur  = goal_reg[cmd.lane];
    assign integ_cur = integ_reg[cmd.lane];
    assign prior_cur = prior_reg[cmd.lane];
    assign goal_zero = (goal_cur == '0);

    always_comb
    begin
        case (cmd.op)
            OP_MEAS:
            begin
                mul_a = sum_reg[cmd.lane];
                mul_b = $signed({1'b0, scale});
            end
            OP_PERIOD:
            begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = $signed({1'b0, cfg.sample_period});
            end
            OP_RATE:
            begin
                mul_a = MUL_A_W'(diff_reg);
                mul_b = $signed({1'b0, cfg.sample_rate});
            end
            OP_KP:
            begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = MUL_B_W'(kp);
            end
            OP_KI:
            begin
                mul_a = MUL_A_W'(integ_cur);
                mul_b = MUL_B_W'(ki);
            end
            OP_KD:
            begin
                mul_a = MUL_A_W'(deriv_reg);
                mul_b = MUL_B_W'(kd);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // The product register always carries the previous step's product forward.
    assign meas_val  = sat32(64'($signed(prod_reg[PROD_W-1:FRAC_SHIFT])));
    assign err_val   = sat32(64'(goal_cur) - 64'(meas_val));
    assign integ_val = sat32(64'(integ_cur) + 64'($signed(prod_reg[PROD_W-1:FRAC_SHIFT])));
    assign acc_sum   = acc_reg + prod_reg;
    assign drive_val = sat32(64'(acc_sum >>> GAIN_SHIFT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LANES; i++)
            begin
                integ_reg[i] <= '0;
                prior_reg[i] <= '0;
            end
        end
        else
        begin
            case (cmd.op)
                OP_RATE:
                begin
                    integ_reg[cmd.lane] <= goal_zero ? '0 : integ_val;
                end
                OP_DRIVE:
                begin
                    prior_reg[cmd.lane] <= err_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;

        if (cmd.load_in)
        begin
            sum_reg[LANE_X]    <= w1 + w2 + w3 + w4;
            sum_reg[LANE_Y]    <= w1 - w2 + w3 - w4;
            sum_reg[LANE_YAW]  <= w1 - w2 - w3 + w4;
            goal_reg[LANE_X]   <= goal_x;
            goal_reg[LANE_Y]   <= goal_y;
            goal_reg[LANE_YAW] <= goal_yaw;
        end

        case (cmd.op)
            OP_ERR:
            begin
                meas_res_reg[cmd.lane] <= meas_val;
                err_res_reg[cmd.lane]  <= err_val;
                err_reg                <= err_val;
            end
            OP_PERIOD:
            begin
                diff_reg <= DIFF_W'(err_reg) - DIFF_W'(prior_cur);
            end
            OP_KP:
            begin
                deriv_reg <= sat32(64'(prod_reg));
            end
            OP_KI:
            begin
                acc_reg <= prod_reg;
            end
            OP_KD:
            begin
                acc_reg <= acc_sum;
            end
            OP_DRIVE:
            begin
                drive_res_reg[cmd.lane] <= goal_zero ? '0 : drive_val;
            end
            default:
            begin
            end
        endcase

        if (cmd.load_out)
        begin
            for (int i = 0; i < NUM_LANES; i++)
            begin
                meas_out_reg[i]  <= meas_res_reg[i];
                err_out_reg[i]   <= err_res_reg[i];
                drive_out_reg[i] <= drive_res_reg[i];
            end
        end
    end

    assign drive_x      = drive_out_reg[LANE_X];
    assign drive_y      = drive_out_reg[LANE_Y];
    assign drive_yaw    = drive_out_reg[LANE_YAW];
    assign measured_x   = meas_out_reg[LANE_X];
    assign measured_y   = meas_out_reg[LANE_Y];
    assign measured_yaw = meas_out_reg[LANE_YAW];
    assign error_x      = err_out_reg[LANE_X];
    assign error_y      = err_out_reg[LANE_Y];
    assign error_yaw    = err_out_reg[LANE_YAW];

endmodule

@@ rtl/core/mvp_checker.sv @@
// Port-level checker for the mecanum velocity PID block and its bind to the top level.
module mvp_checker
    import mvp_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [DATA_W-1:0] drive_x
);

    // Once a sample is taken, the block does not stay ready for a further sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
    else $error("sample accepted while the previous one is still in progress");

    // A fresh result appears only when the block was not ready for a sample just before it.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
    else $error("result presented without the sequencer finishing its work");

    // A sample transfer never yields a result on the very next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared directly after a sample transfer");

    // A result waiting for its transfer keeps its valid and its drive_x value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(drive_x)))
    else $error("pending result dropped or changed before its transfer");

endmodule

bind mecanum_velocity_pid_top mvp_checker u_mvp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample_in.valid),
    .in_ready  (sample_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .drive_x   (result_out.drive_x)
);
